FILE: rtl/tga_rle_pixel_decoder_macros.svh
// assertion helpers for the tga rle pixel decoder
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tga_rle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tga_rle_pkg;

	localparam int PIXEL_COUNT_BITS_DEF = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_BYTES_PER_PIXEL = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_PIXELS = 1'd1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	// pixel request handed from the parser to the counter
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] count;
		logic       packet_end;
	} pix_cmd_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] repeat_count;
		logic       image_done;
		logic       status;
	} pix_res_t;

	localparam int CMD_W = $bits(pix_cmd_t);
	localparam int RES_W = $bits(pix_res_t);

endpackage
`default_nettype wire

FILE: rtl/tga_rle_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module tga_rle_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] dout,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/tga_rle_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tga_rle_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  four_bpp,
	output logic                       cmd_push,
	output tga_rle_pkg::pix_cmd_t      cmd
);
	import tga_rle_pkg::*;

	logic       expect_header_q;
	logic       run_q;
	logic [7:0] left_q;
	logic [1:0] idx_q;
	logic [7:0] blue_q;
	logic [7:0] green_q;
	logic [7:0] red_q;

	logic       complete;
	logic [7:0] n;
	logic [7:0] left_next;

	always_comb begin
		complete  = four_bpp ? (idx_q == 2'd3) : (idx_q >= 2'd2);
		n         = run_q ? left_q : 8'd1;
		left_next = left_q - n;

		cmd.red        = (idx_q == 2'd2) ? data_byte : red_q;
		cmd.green      = green_q;
		cmd.blue       = blue_q;
		cmd.alpha      = four_bpp ? data_byte : 8'd0;
		cmd.count      = n;
		cmd.packet_end = (left_next == 8'd0);
	end

	assign cmd_push = accept && !expect_header_q && complete;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			run_q           <= 1'b0;
			left_q          <= '0;
			idx_q           <= '0;
		end else if (accept) begin
			if (expect_header_q) begin
				// raw: h+1 pixels, run: h-127 pixels, both are low seven bits plus one
				run_q           <= data_byte[7];
				left_q          <= {1'b0, data_byte[6:0]} + 8'd1;
				idx_q           <= '0;
				expect_header_q <= 1'b0;
			end else if (!complete) begin
				idx_q <= idx_q + 2'd1;
			end else begin
				idx_q  <= '0;
				left_q <= left_next;
				if (left_next == 8'd0) begin
					expect_header_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !expect_header_q) begin
			unique case (idx_q)
				2'd0: blue_q <= data_byte;
				2'd1: green_q <= data_byte;
				2'd2: red_q <= data_byte;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/tga_rle_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tga_rle_back #(
	parameter int PIXEL_COUNT_BITS = tga_rle_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	input  wire tga_rle_pkg::pix_cmd_t       cmd,
	output logic                             cmd_pop,
	input  wire logic                        res_full,
	output logic                             res_push,
	output tga_rle_pkg::pix_res_t            res,
	input  wire logic [PIXEL_COUNT_BITS-1:0] total
);
	import tga_rle_pkg::*;

	logic [PIXEL_COUNT_BITS-1:0] written_q;
	logic                        stopped_q;

	logic [PIXEL_COUNT_BITS:0]   sum;
	logic                        overflow;
	logic                        done;

	always_comb begin
		sum      = {1'b0, written_q} + {{(PIXEL_COUNT_BITS + 1 - 8){1'b0}}, cmd.count};
		overflow = (sum > {1'b0, total});
		done     = (sum[PIXEL_COUNT_BITS-1:0] == total);

		if (overflow) begin
			res = '0;
			res.status = STATUS_OVERFLOW;
		end else begin
			res.red          = cmd.red;
			res.green        = cmd.green;
			res.blue         = cmd.blue;
			res.alpha        = cmd.alpha;
			res.repeat_count = cmd.count;
			res.image_done   = done;
			res.status       = STATUS_OK;
		end
	end

	assign cmd_pop  = cmd_valid && !res_full;
	// once stopped, requests are drained and dropped
	assign res_push = cmd_pop && !stopped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			stopped_q <= 1'b0;
		end else if (res_push) begin
			if (overflow) begin
				stopped_q <= 1'b1;
			end else begin
				written_q <= sum[PIXEL_COUNT_BITS-1:0];
				if (done && cmd.packet_end) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// TGA run-length pixel decoder.
// Input queue: data_byte is taken at each clock edge with push high and full low, one
// byte of the packet stream per cycle (header bytes and BGR/BGRA color bytes).
// Result queue: while empty is low the oldest pixel sits on red/green/blue/alpha,
// repeat_count, image_done and status; it leaves at an edge with pop high.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index (0 = four bytes per
// pixel, 1 = total pixels) at once; write only while no request is in flight.
// Path: the parser pushes a pixel request into a two-entry queue as the byte that
// completes its pixel is taken; the counter takes it once the result queue has room
// and loads a two-entry result queue. The count add and compare are combinational.
// Throughput: one byte per cycle while full is low.
// Reset clears both queues, the parser state and the pixel count; registers return
// to 24-bit pixels and a total of one. After completion or overflow the block keeps
// taking bytes and drops them until the next reset.
// When pop stays low the result queue fills, then the request queue, then full rises.
module tga_rle_pixel_decoder #(
	parameter int PIXEL_COUNT_BITS = tga_rle_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [7:0]                         data_byte,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic [7:0]                              red,
	output logic [7:0]                              green,
	output logic [7:0]                              blue,
	output logic [7:0]                              alpha,
	output logic [7:0]                              repeat_count,
	output logic                                    image_done,
	output logic                                    status,
	input  wire logic                               cfg_wr_en,
	input  wire logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tga_rle_pkg::*;

	logic                        four_bpp_q;
	logic [PIXEL_COUNT_BITS-1:0] total_q;

	logic             accept;
	logic             cmd_push;
	pix_cmd_t         cmd_in;
	logic [CMD_W-1:0] cmd_out_raw;
	pix_cmd_t         cmd_out;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             res_push;
	pix_res_t         res_in;
	logic             res_full;
	logic [RES_W-1:0] res_out_raw;
	pix_res_t         res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bpp_q <= 1'b0;
			total_q    <= PIXEL_COUNT_BITS'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FOUR_BYTES_PER_PIXEL: four_bpp_q <= cfg_data[0];
				CFG_TOTAL_PIXELS: total_q <= cfg_data[PIXEL_COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign accept = push && !full;

	tga_rle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.four_bpp  (four_bpp_q),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	tga_rle_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd_out_raw),
		.empty  (cmd_empty)
	);

	assign cmd_out = pix_cmd_t'(cmd_out_raw);

	tga_rle_back #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in),
		.total     (total_q)
	);

	tga_rle_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out_raw),
		.empty  (empty)
	);

	assign res_out      = pix_res_t'(res_out_raw);
	assign red          = res_out.red;
	assign green        = res_out.green;
	assign blue         = res_out.blue;
	assign alpha        = res_out.alpha;
	assign repeat_count = res_out.repeat_count;
	assign image_done   = res_out.image_done;
	assign status       = res_out.status;

endmodule
`default_nettype wire

FILE: rtl/tga_rle_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"
module tga_rle_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue,
	input wire logic [7:0] alpha,
	input wire logic [7:0] repeat_count,
	input wire logic       image_done,
	input wire logic       status
);
	import tga_rle_pkg::*;

	// an overflow result carries no pixel
	`TRD_ASSERT_NOW(a_err_zero, !empty && status == STATUS_OVERFLOW, red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0 && repeat_count == 8'd0 && !image_done, "overflow result with pixel data")
	// a good pixel covers one to 128 positions
	`TRD_ASSERT_NOW(a_rep_range, !empty && status == STATUS_OK, repeat_count != 8'd0 && repeat_count <= 8'd128, "repeat count out of range")
	// nothing follows an overflow
	`TRD_ASSERT_NEXT(a_err_last, !empty && pop && status == STATUS_OVERFLOW, empty, "result after overflow")
	// a waiting result holds still
	`TRD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(red) && $stable(repeat_count) && $stable(status), "waiting result changed")

endmodule

bind tga_rle_pixel_decoder tga_rle_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.red          (red),
	.green        (green),
	.blue         (blue),
	.alpha        (alpha),
	.repeat_count (repeat_count),
	.image_done   (image_done),
	.status       (status)
);
`default_nettype wire

FILE: tb/tb_tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
module tb_tga_rle_pixel_decoder;
	import tga_rle_pkg::*;

	localparam int RAND_BYTES = 1100;
	localparam int HOLD_PHASE = 2;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 10;
	localparam int WATCHDOG = 3000;
	localparam logic [31:0] TOTAL_MAX = 32'hFFFE_0001;

	typedef enum logic [1:0] {ROW_BYTE, ROW_MODE} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [7:0] value;
		bit         typed;
		pix_res_t   res;
	} stim_row_t;

	localparam pix_res_t PIX_NONE = '0;
	localparam pix_res_t PIX_BLACK = '{8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b0, STATUS_OK};
	localparam pix_res_t PIX_RUN_MAX = '{8'h03, 8'h02, 8'h01, 8'h00, 8'd128, 1'b0, STATUS_OK};
	localparam pix_res_t PIX_WHITE = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'd1, 1'b0, STATUS_OK};

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	logic [7:0]             data_byte;
	logic                   empty;
	logic                   pop;
	logic [7:0]             red;
	logic [7:0]             green;
	logic [7:0]             blue;
	logic [7:0]             alpha;
	logic [7:0]             repeat_count;
	logic                   image_done;
	logic                   status;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// decoder state as the testbench sees it
	bit          bgra_mode;
	logic [31:0] pixel_total;
	bit          want_header;
	bit          in_run;
	logic [7:0]  left_in_pkt;
	logic [1:0]  byte_pos;
	logic [7:0]  color [4];
	logic [31:0] pixels_so_far;
	bit          halted;

	pix_res_t pixel_q[$];
	int       mismatches = 0;
	int       stall_cycles = 0;
	bit       tx_fast = 1'b0;
	bit       hold_req = 1'b0;

	stim_row_t dir_rows [27] = '{
		'{ROW_BYTE, 8'h00, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h00, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h00, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h00, 1'b1, PIX_BLACK},
		'{ROW_BYTE, 8'hFF, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h01, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h02, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h03, 1'b1, PIX_RUN_MAX},
		'{ROW_BYTE, 8'h80, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'hFF, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'hFF, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'hFF, 1'b1, PIX_WHITE},
		'{ROW_BYTE, 8'h01, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h10, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h20, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h30, 1'b0, PIX_NONE},
		// switch to bgra between the two pixels of a raw packet
		'{ROW_MODE, 8'h01, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h40, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h50, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h60, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h70, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'h81, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'hAA, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'hBB, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'hCC, 1'b0, PIX_NONE},
		// back to bgr with three bytes already stored
		'{ROW_MODE, 8'h00, 1'b0, PIX_NONE},
		'{ROW_BYTE, 8'hDD, 1'b0, PIX_NONE}
	};

	tga_rle_pixel_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.empty        (empty),
		.pop          (pop),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.repeat_count (repeat_count),
		.image_done   (image_done),
		.status       (status),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit decode_byte(input logic [7:0] b, output pix_res_t p);
		logic [32:0] sum;
		logic [7:0]  n;
		int          psize;
		p = '0;
		psize = bgra_mode ? 4 : 3;
		if (halted)
			return 1'b0;
		if (want_header) begin
			in_run = b[7];
			left_in_pkt = b[7] ? b - 8'd127 : b + 8'd1;
			byte_pos = 2'd0;
			want_header = 1'b0;
			return 1'b0;
		end
		color[byte_pos] = b;
		if (int'(byte_pos) + 1 < psize) begin
			byte_pos = byte_pos + 2'd1;
			return 1'b0;
		end
		byte_pos = 2'd0;
		n = in_run ? left_in_pkt : 8'd1;
		sum = {1'b0, pixels_so_far} + {25'd0, n};
		if (sum > {1'b0, pixel_total}) begin
			p.status = STATUS_OVERFLOW;
			halted = 1'b1;
			return 1'b1;
		end
		pixels_so_far = sum[31:0];
		left_in_pkt = left_in_pkt - n;
		if (left_in_pkt == 8'd0)
			want_header = 1'b1;
		p.red = color[2];
		p.green = color[1];
		p.blue = color[0];
		p.alpha = bgra_mode ? color[3] : 8'h00;
		p.repeat_count = n;
		p.image_done = (pixels_so_far == pixel_total);
		p.status = STATUS_OK;
		// the image is finished only once its last packet is closed
		if (p.image_done && want_header)
			halted = 1'b1;
		return 1'b1;
	endfunction

	// mostly short packets, so that many headers go by
	function automatic logic [7:0] next_byte();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (want_header) begin
			if (pick < 5)
				return 8'($urandom_range(0, 3));
			if (pick == 5)
				return 8'($urandom_range(0, 127));
			return 8'($urandom_range(128, 255));
		end
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	task automatic report(input string msg);
		if (mismatches < 40)
			$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send_byte(input logic [7:0] b, input bit typed, input pix_res_t want);
		int       gap;
		pix_res_t p;
		bit       made;
		gap = tx_fast ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (full);
		made = decode_byte(b, p);
		if (made || typed)
			pixel_q.push_back(typed ? want : p);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_FOUR_BYTES_PER_PIXEL)
			bgra_mode = val[0];
		else
			pixel_total = val;
	endtask

	// stop sending and let the pipeline drain before touching registers
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : byte_side
		int sent;
		int len;
		int ph;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		data_byte = 8'h00;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_FOUR_BYTES_PER_PIXEL;
		cfg_data = '0;
		bgra_mode = 1'b0;
		pixel_total = 32'd1;
		want_header = 1'b1;
		in_run = 1'b0;
		left_in_pkt = 8'd0;
		byte_pos = 2'd0;
		color = '{8'h00, 8'h00, 8'h00, 8'h00};
		pixels_so_far = 32'd0;
		halted = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_TOTAL_PIXELS, 32'd1);
		write_reg(CFG_FOUR_BYTES_PER_PIXEL, 32'd1);
		write_reg(CFG_FOUR_BYTES_PER_PIXEL, 32'd0);
		write_reg(CFG_TOTAL_PIXELS, TOTAL_MAX);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_MODE) begin
				settle();
				write_reg(CFG_FOUR_BYTES_PER_PIXEL, {24'd0, dir_rows[i].value});
			end else begin
				send_byte(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);
			end
		end

		sent = 0;
		ph = 0;
		while (sent < RAND_BYTES) begin
			settle();
			write_reg(CFG_FOUR_BYTES_PER_PIXEL, $urandom_range(0, 1));
			if (ph % 3 == 1)
				write_reg(CFG_TOTAL_PIXELS,
					$urandom_range(TOTAL_MAX, pixels_so_far + 32'd100000));
			tx_fast = (ph == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
			// receiver backs off while requests keep coming, so full has to rise
			if (ph == HOLD_PHASE)
				hold_req = 1'b1;
			len = (ph == HOLD_PHASE) ? 150 : $urandom_range(20, 120);
			repeat (len) send_byte(next_byte(), 1'b0, PIX_NONE);
			sent += len;
			ph++;
		end

		// close the open packet, then finish the image two pixels into a raw packet
		tx_fast = 1'b0;
		while (!want_header) send_byte(next_byte(), 1'b0, PIX_NONE);
		settle();
		write_reg(CFG_TOTAL_PIXELS, pixels_so_far + 32'd2);
		send_byte(8'h04, 1'b0, PIX_NONE);
		repeat (5 * (bgra_mode ? 4 : 3) + 6) send_byte(8'($urandom), 1'b0, PIX_NONE);
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : result_side
		int       gap;
		int       n_res;
		bit       rx_fast;
		pix_res_t got;
		pix_res_t want;
		n_res = 0;
		rx_fast = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				@(negedge clk);
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = rx_fast ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				@(negedge clk);
				pop <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got = {red, green, blue, alpha, repeat_count, image_done, status};
			if (pixel_q.size() == 0) begin
				report($sformatf("unexpected pixel %h", got));
			end else begin
				want = pixel_q.pop_front();
				if (got.red !== want.red)
					report($sformatf("pixel %0d red %h, want %h", n_res, got.red, want.red));
				if (got.green !== want.green)
					report($sformatf("pixel %0d green %h, want %h", n_res, got.green,
						want.green));
				if (got.blue !== want.blue)
					report($sformatf("pixel %0d blue %h, want %h", n_res, got.blue,
						want.blue));
				if (got.alpha !== want.alpha)
					report($sformatf("pixel %0d alpha %h, want %h", n_res, got.alpha,
						want.alpha));
				if (got.repeat_count !== want.repeat_count)
					report($sformatf("pixel %0d repeat_count %0d, want %0d", n_res,
						got.repeat_count, want.repeat_count));
				if (got.image_done !== want.image_done)
					report($sformatf("pixel %0d image_done %b, want %b", n_res,
						got.image_done, want.image_done));
				if (got.status !== want.status)
					report($sformatf("pixel %0d status %b, want %b", n_res, got.status,
						want.status));
			end
			n_res++;
			if (n_res % 40 == 0)
				rx_fast = ($urandom_range(0, 2) == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
